@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is high
`define LLE_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define LLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/lle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lle_pkg
// shared types, register indexes and saturation helper of the lineshape block
// ----------------------------------------------------------------------------
package lle_pkg;

   localparam int FRAC_STEPS   = 32;
   localparam int QUOT_STEPS   = 34;
   localparam int NUM_PARTIALS = 4;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_PEAK_POSITION = 2'd0;
   localparam csr_index_type CSR_LORENTZ_WIDTH = 2'd1;
   localparam csr_index_type CSR_PEAK_HEIGHT   = 2'd2;
   localparam csr_index_type CSR_GRADIENTS_ON  = 2'd3;

   // partial slots
   localparam int P_POS_RE   = 0;
   localparam int P_POS_IM   = 1;
   localparam int P_WIDTH_RE = 2;
   localparam int P_WIDTH_IM = 3;

   typedef struct packed {
      logic valid;
      logic neg;
   } fsb_type;

   typedef struct packed {
      logic                    valid;
      logic [32:0]             fre_mag;
      logic                    fre_neg;
      logic [32:0]             fim_mag;
      logic                    fim_neg;
      logic signed [31:0]      dh_re;
      logic signed [31:0]      dh_im;
      logic [NUM_PARTIALS-1:0] p_neg;
   } qsb_type;

   typedef struct packed {
      logic signed [31:0] fit_re;
      logic signed [31:0] fit_im;
      logic signed [31:0] dpos_re;
      logic signed [31:0] dpos_im;
      logic signed [31:0] dwidth_re;
      logic signed [31:0] dwidth_im;
      logic signed [31:0] dheight_re;
      logic signed [31:0] dheight_im;
      logic               overflow;
   } res_type;

   // signed saturation of a magnitude, bit 32 flags saturation
   function automatic logic [32:0] sat32(input logic [33:0] mag, input logic neg);
      logic [32:0] r;
      if (neg) begin
         if (mag > 34'h0_8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'(32'd0 - mag[31:0])};
      end else begin
         if (mag > 34'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[31:0]};
      end
      return r;
   endfunction

endpackage

@@ hdl/lle_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lle_req_if / lle_rsp_if
// valid/ready channels for spectral points and lineshape results
// ----------------------------------------------------------------------------
interface lle_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_value;

   modport source (output valid, output x_value, input ready);
   modport sink (input valid, input x_value, output ready);
endinterface

interface lle_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] fit_re;
   logic signed [31:0] fit_im;
   logic signed [31:0] dpos_re;
   logic signed [31:0] dpos_im;
   logic signed [31:0] dwidth_re;
   logic signed [31:0] dwidth_im;
   logic signed [31:0] dheight_re;
   logic signed [31:0] dheight_im;
   logic               overflow;

   modport source (output valid, output fit_re, output fit_im, output dpos_re,
                   output dpos_im, output dwidth_re, output dwidth_im,
                   output dheight_re, output dheight_im, output overflow,
                   input ready);
   modport sink (input valid, input fit_re, input fit_im, input dpos_re,
                 input dpos_im, input dwidth_re, input dwidth_im,
                 input dheight_re, input dheight_im, input overflow,
                 output ready);
endinterface

@@ hdl/lle_frac_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lle_frac_div
// pipelined restoring divider, floor(num * 2^31 / den) for num <= den
// ----------------------------------------------------------------------------
module lle_frac_div (
   input  logic        clock,
   input  logic        en,
   input  logic [61:0] num_in,
   input  logic [62:0] den_in,
   output logic [31:0] q_out
);

   localparam int N = lle_pkg::FRAC_STEPS;

   logic [62:0] r_ff   [N];
   logic [62:0] den_ff [N];
   logic [31:0] q_ff   [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [62:0] r_src;
      logic [62:0] den_src;
      logic [31:0] q_src;
      logic [63:0] r_sh;
      logic        ge;
      logic [62:0] r_in;
      logic [31:0] q_in;

      if (i == 0) begin : g_first
         // integer bit: no shift
         assign r_src   = {1'b0, num_in};
         assign den_src = den_in;
         assign q_src   = '0;
         assign r_sh    = {1'b0, r_src};
      end else begin : g_next
         assign r_src   = r_ff[i-1];
         assign den_src = den_ff[i-1];
         assign q_src   = q_ff[i-1];
         assign r_sh    = {r_src, 1'b0};
      end

      assign ge   = r_sh >= {1'b0, den_src};
      assign r_in = ge ? 63'(r_sh - {1'b0, den_src}) : r_sh[62:0];
      assign q_in = {q_src[30:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i]   <= r_in;
            den_ff[i] <= den_src;
            q_ff[i]   <= q_in;
         end
      end
   end

   assign q_out = q_ff[N-1];

endmodule

@@ hdl/lle_quot_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lle_quot_div
// pipelined restoring divider, 33 quotient bits plus a too-large flag
// ----------------------------------------------------------------------------
module lle_quot_div (
   input  logic        clock,
   input  logic        en,
   input  logic [62:0] num_in,
   input  logic [44:0] den_in,
   output logic [32:0] q_out,
   output logic        big_out
);

   localparam int N = lle_pkg::QUOT_STEPS;

   logic [44:0] p_ff    [N];
   logic [32:0] rest_ff [N];
   logic [44:0] den_ff  [N];
   logic [32:0] q_ff    [N];
   logic        big_ff  [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [44:0] den_src;
      logic [44:0] p_in;
      logic [32:0] rest_in;
      logic [32:0] q_in;
      logic        big_in;

      if (i == 0) begin : g_first
         // upper bits at or above den mean a quotient of 2^33 or more
         assign den_src = den_in;
         assign p_in    = {15'd0, num_in[62:33]};
         assign rest_in = num_in[32:0];
         assign q_in    = '0;
         assign big_in  = {15'd0, num_in[62:33]} >= den_in;
      end else begin : g_next
         logic [45:0] ps;
         logic        ge;
         assign den_src = den_ff[i-1];
         assign ps      = {p_ff[i-1], rest_ff[i-1][32]};
         assign ge      = ps >= {1'b0, den_src};
         assign p_in    = ge ? 45'(ps - {1'b0, den_src}) : ps[44:0];
         assign rest_in = {rest_ff[i-1][31:0], 1'b0};
         assign q_in    = {q_ff[i-1][31:0], ge};
         assign big_in  = big_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[i]    <= p_in;
            rest_ff[i] <= rest_in;
            den_ff[i]  <= den_src;
            q_ff[i]    <= q_in;
            big_ff[i]  <= big_in;
         end
      end
   end

   assign q_out   = q_ff[N-1];
   assign big_out = big_ff[N-1];

endmodule

@@ hdl/lle_out_buf.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lle_out_buf
// output register with skid entry; room drops when the skid entry is taken
// ----------------------------------------------------------------------------
module lle_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lle_pkg::res_type  push_data,
   output logic              room,
   lle_rsp_if.source         rsp_chan
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   lle_pkg::res_type main_ff, main_in;
   lle_pkg::res_type skid_ff, skid_in;
   logic             pop;

   assign pop  = main_valid_ff && rsp_chan.ready;
   assign room = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid      = main_valid_ff;
   assign rsp_chan.fit_re     = main_ff.fit_re;
   assign rsp_chan.fit_im     = main_ff.fit_im;
   assign rsp_chan.dpos_re    = main_ff.dpos_re;
   assign rsp_chan.dpos_im    = main_ff.dpos_im;
   assign rsp_chan.dwidth_re  = main_ff.dwidth_re;
   assign rsp_chan.dwidth_im  = main_ff.dwidth_im;
   assign rsp_chan.dheight_re = main_ff.dheight_re;
   assign rsp_chan.dheight_im = main_ff.dheight_im;
   assign rsp_chan.overflow   = main_ff.overflow;

   `LLE_ASSERT_RST(a_no_push_when_full, clock, reset, push |-> !skid_valid_ff, "push into full buffer")
   `LLE_ASSERT_RST(a_skid_behind_main, clock, reset, skid_valid_ff |-> main_valid_ff, "skid without main")
   `LLE_ASSERT_RST(a_drain_empty, clock, reset, (pop && !push && !skid_valid_ff) |=> !main_valid_ff, "drain kept data")

endmodule

@@ hdl/lorentz_lineshape_eval.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lorentz_lineshape_eval
// complex lorentzian h*(1+iz)/(1+z^2) with position, width and height partials
// ----------------------------------------------------------------------------
//  channel   ports      direction  carries
//  request   req_chan   in         x_value, signed q16.16
//  result    rsp_chan   out        fit, dpos, dwidth, dheight (re/im), overflow
//  config    csr_*      in         write enable, index, 32 bit data
//
//  one request per cycle while the skid entry is free; 77 register stages lie
//  between an accepted request and its rsp valid
//  stages: 32 in the fraction dividers for a and b, 34 in the dividers for the
//  position and width partials, plus 10 arithmetic stages and the output reg
//  reset is synchronous, clears valids and loads register reset values
//  the whole pipe advances together; a stalled result parks in a skid entry and
//  requests keep flowing until that entry is occupied
// ----------------------------------------------------------------------------
module lorentz_lineshape_eval (
   input  logic                  clock,
   input  logic                  reset,
   lle_req_if.sink               req_chan,
   lle_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  lle_pkg::csr_index_type csr_index,
   input  logic [31:0]           csr_wr_data
);

   localparam int FN = lle_pkg::FRAC_STEPS;
   localparam int QN = lle_pkg::QUOT_STEPS;
   localparam int NP = lle_pkg::NUM_PARTIALS;

   // ---------------- config registers ----------------
   logic signed [31:0] peak_position_ff;
   logic [30:0]        lorentz_width_ff;
   logic signed [31:0] peak_height_ff;
   logic               gradients_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_position_ff <= 32'sd0;
         lorentz_width_ff <= 31'd65536;
         peak_height_ff   <= 32'sd65536;
         gradients_on_ff  <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            lle_pkg::CSR_PEAK_POSITION: peak_position_ff <= csr_wr_data;
            lle_pkg::CSR_LORENTZ_WIDTH: lorentz_width_ff <= csr_wr_data[30:0];
            lle_pkg::CSR_PEAK_HEIGHT:   peak_height_ff   <= csr_wr_data;
            lle_pkg::CSR_GRADIENTS_ON:  gradients_on_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // values derived from config, used only deep in the pipe
   logic [31:0] cfg_hmag_ff;
   logic        cfg_hneg_ff;
   logic [44:0] cfg_wden_ff;
   logic [43:0] cfg_whalf_ff;

   always_ff @(posedge clock) begin
      cfg_hneg_ff  <= peak_height_ff[31];
      cfg_hmag_ff  <= peak_height_ff[31] ? 32'(32'd0 - peak_height_ff) : peak_height_ff;
      cfg_wden_ff  <= {lorentz_width_ff, 14'd0};
      cfg_whalf_ff <= {lorentz_width_ff, 13'd0};
   end

   // ---------------- flow control ----------------
   logic             advance;
   logic             push;
   lle_pkg::res_type res;

   assign req_chan.ready = advance;

   // s1: offset d = x - p
   logic               s1_valid_ff;
   logic signed [32:0] s1_d_ff;
   // s2: magnitude and far-point halving
   logic               s2_valid_ff;
   logic [30:0]        s2_dm_ff, s2_wm_ff;
   logic               s2_neg_ff;
   // s3: squares and cross product
   logic               s3_valid_ff;
   logic [61:0]        s3_ww_ff, s3_dd_ff, s3_dw_ff;
   logic               s3_neg_ff;
   // s4: denominator
   logic               s4_valid_ff;
   logic [62:0]        s4_den_ff;
   logic [61:0]        s4_ww_ff, s4_dw_ff;
   logic               s4_neg_ff;

   logic [32:0] s2_dmag;
   logic        s2_far;
   assign s2_dmag = s1_d_ff[32] ? 33'(33'd0 - s1_d_ff) : s1_d_ff;
   assign s2_far  = s2_dmag[32] || s2_dmag[31];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_d_ff   <= 33'(signed'(req_chan.x_value)) - 33'(signed'(peak_position_ff));
         s2_neg_ff <= s1_d_ff[32];
         s2_dm_ff  <= s2_far ? s2_dmag[31:1] : s2_dmag[30:0];
         s2_wm_ff  <= s2_far ? {1'b0, lorentz_width_ff[30:1]} : lorentz_width_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_ww_ff  <= 62'(s2_wm_ff) * 62'(s2_wm_ff);
         s3_dd_ff  <= 62'(s2_dm_ff) * 62'(s2_dm_ff);
         s3_dw_ff  <= 62'(s2_dm_ff) * 62'(s2_wm_ff);
         s4_neg_ff <= s3_neg_ff;
         s4_den_ff <= {1'b0, s3_ww_ff} + {1'b0, s3_dd_ff};
         s4_ww_ff  <= s3_ww_ff;
         s4_dw_ff  <= s3_dw_ff;
      end
   end

   // ---------------- fraction dividers: a = w^2/D, b = |d|w/D ----------------
   logic [31:0]      qa, qb;
   lle_pkg::fsb_type fsb_ff [FN];

   lle_frac_div u_div_a (
      .clock(clock), .en(advance), .num_in(s4_ww_ff), .den_in(s4_den_ff), .q_out(qa)
   );
   lle_frac_div u_div_b (
      .clock(clock), .en(advance), .num_in(s4_dw_ff), .den_in(s4_den_ff), .q_out(qb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FN; i++) fsb_ff[i].valid <= 1'b0;
      end else if (advance) begin
         fsb_ff[0] <= '{valid: s4_valid_ff, neg: s4_neg_ff};
         for (int i = 1; i < FN; i++) fsb_ff[i] <= fsb_ff[i-1];
      end
   end

   // s5: round to q.30 and form c = 1 - 2a
   logic [32:0]        s5_qa_sum, s5_qb_sum;
   logic signed [31:0] s5_c;
   assign s5_qa_sum = 33'(qa) + 33'd1;
   assign s5_qb_sum = 33'(qb) + 33'd1;
   assign s5_c      = 32'sh4000_0000 - signed'({s5_qa_sum[31:1], 1'b0});

   logic        s5_valid_ff;
   logic [30:0] s5_a_ff, s5_bm_ff, s5_cmag_ff;
   logic        s5_bneg_ff, s5_cneg_ff;
   // s6: products
   logic        s6_valid_ff;
   logic [62:0] s6_ha_ff, s6_hb_ff;
   logic [61:0] s6_aa_ff, s6_ab_ff, s6_bb_ff, s6_bc_ff;
   logic [30:0] s6_a_ff, s6_bm_ff;
   logic        s6_bneg_ff, s6_cneg_ff;
   // s7: rounded products
   logic        s7_valid_ff;
   logic [32:0] s7_fre_ff, s7_fim_ff;
   logic [30:0] s7_ab_ff, s7_aa_ff, s7_bb_ff, s7_bc_ff;
   logic [17:0] s7_dhre_ff, s7_dhim_ff;
   logic        s7_bneg_ff, s7_cneg_ff;

   logic [62:0] s7_ha_r, s7_hb_r;
   logic [61:0] s7_aa_r, s7_ab_r, s7_bb_r, s7_bc_r;
   logic [31:0] s7_dhre_r, s7_dhim_r;
   assign s7_ha_r   = s6_ha_ff + 63'h2000_0000;
   assign s7_hb_r   = s6_hb_ff + 63'h2000_0000;
   assign s7_aa_r   = s6_aa_ff + 62'h2000_0000;
   assign s7_ab_r   = s6_ab_ff + 62'h2000_0000;
   assign s7_bb_r   = s6_bb_ff + 62'h2000_0000;
   assign s7_bc_r   = s6_bc_ff + 62'h2000_0000;
   assign s7_dhre_r = 32'(s6_a_ff) + 32'h2000;
   assign s7_dhim_r = 32'(s6_bm_ff) + 32'h2000;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= fsb_ff[FN-1].valid;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_a_ff    <= s5_qa_sum[31:1];
         s5_bm_ff   <= s5_qb_sum[31:1];
         s5_bneg_ff <= fsb_ff[FN-1].neg;
         s5_cneg_ff <= s5_c[31];
         s5_cmag_ff <= s5_c[31] ? 31'(32'd0 - s5_c) : s5_c[30:0];

         s6_ha_ff   <= 63'(cfg_hmag_ff) * 63'(s5_a_ff);
         s6_hb_ff   <= 63'(cfg_hmag_ff) * 63'(s5_bm_ff);
         s6_aa_ff   <= 62'(s5_a_ff) * 62'(s5_a_ff);
         s6_ab_ff   <= 62'(s5_a_ff) * 62'(s5_bm_ff);
         s6_bb_ff   <= 62'(s5_bm_ff) * 62'(s5_bm_ff);
         s6_bc_ff   <= 62'(s5_bm_ff) * 62'(s5_cmag_ff);
         s6_a_ff    <= s5_a_ff;
         s6_bm_ff   <= s5_bm_ff;
         s6_bneg_ff <= s5_bneg_ff;
         s6_cneg_ff <= s5_cneg_ff;

         s7_fre_ff  <= s7_ha_r[62:30];
         s7_fim_ff  <= s7_hb_r[62:30];
         s7_aa_ff   <= s7_aa_r[60:30];
         s7_ab_ff   <= s7_ab_r[60:30];
         s7_bb_ff   <= s7_bb_r[60:30];
         s7_bc_ff   <= s7_bc_r[60:30];
         s7_dhre_ff <= s7_dhre_r[31:14];
         s7_dhim_ff <= s7_dhim_r[31:14];
         s7_bneg_ff <= s6_bneg_ff;
         s7_cneg_ff <= s6_cneg_ff;
      end
   end

   // s8: partial numerators as magnitude and sign
   logic signed [31:0] s8_diff;
   logic [31:0]        s8_dhre, s8_dhim;
   lle_pkg::qsb_type   s8_sb_in, s8_sb_ff, s9_sb_ff, s10_sb_ff;
   logic [31:0]        s8_nmag_in [NP];
   logic [31:0]        s8_nmag_ff [NP];
   logic [63:0]        s9_pn_ff   [NP];
   logic [62:0]        s10_nn_ff  [NP];

   assign s8_diff = signed'({1'b0, s7_bb_ff}) - signed'({1'b0, s7_aa_ff});
   assign s8_dhre = {14'd0, s7_dhre_ff};
   assign s8_dhim = s7_bneg_ff ? 32'(32'd0 - {14'd0, s7_dhim_ff}) : {14'd0, s7_dhim_ff};

   always_comb begin
      s8_sb_in.valid   = s7_valid_ff;
      s8_sb_in.fre_mag = s7_fre_ff;
      s8_sb_in.fre_neg = cfg_hneg_ff;
      s8_sb_in.fim_mag = s7_fim_ff;
      s8_sb_in.fim_neg = cfg_hneg_ff ^ s7_bneg_ff;
      s8_sb_in.dh_re   = s8_dhre;
      s8_sb_in.dh_im   = s8_dhim;
      s8_sb_in.p_neg[lle_pkg::P_POS_RE]   = s7_bneg_ff;
      s8_sb_in.p_neg[lle_pkg::P_POS_IM]   = s8_diff[31];
      s8_sb_in.p_neg[lle_pkg::P_WIDTH_RE] = 1'b0;
      s8_sb_in.p_neg[lle_pkg::P_WIDTH_IM] = s7_bneg_ff ^ s7_cneg_ff;
      // partial signs also carry the sign of h
      s8_sb_in.p_neg = s8_sb_in.p_neg ^ {NP{cfg_hneg_ff}};
      s8_nmag_in[lle_pkg::P_POS_RE]   = {s7_ab_ff, 1'b0};
      s8_nmag_in[lle_pkg::P_POS_IM]   = s8_diff[31] ? 32'(32'd0 - s8_diff) : s8_diff;
      s8_nmag_in[lle_pkg::P_WIDTH_RE] = {s7_bb_ff, 1'b0};
      s8_nmag_in[lle_pkg::P_WIDTH_IM] = {1'b0, s7_bc_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_sb_ff.valid  <= 1'b0;
         s9_sb_ff.valid  <= 1'b0;
         s10_sb_ff.valid <= 1'b0;
      end else if (advance) begin
         s8_sb_ff        <= s8_sb_in;
         s9_sb_ff        <= s8_sb_ff;
         s10_sb_ff       <= s9_sb_ff;
      end
   end

   // s9: h*N, s10: add half the divisor for rounding
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NP; k++) begin
            s8_nmag_ff[k] <= s8_nmag_in[k];
            s9_pn_ff[k]   <= 64'(cfg_hmag_ff) * 64'(s8_nmag_ff[k]);
            s10_nn_ff[k]  <= s9_pn_ff[k][62:0] + 63'(cfg_whalf_ff);
         end
      end
   end

   // ---------------- partial dividers: h*N / (w * 2^14) ----------------
   logic [32:0]      pq  [NP];
   logic             pbig[NP];
   lle_pkg::qsb_type qsb_ff [QN];

   for (genvar k = 0; k < NP; k++) begin : g_pdiv
      lle_quot_div u_div (
         .clock(clock), .en(advance), .num_in(s10_nn_ff[k]), .den_in(cfg_wden_ff),
         .q_out(pq[k]), .big_out(pbig[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QN; i++) qsb_ff[i].valid <= 1'b0;
      end else if (advance) begin
         qsb_ff[0] <= s10_sb_ff;
         for (int i = 1; i < QN; i++) qsb_ff[i] <= qsb_ff[i-1];
      end
   end

   // ---------------- saturation and result assembly ----------------
   logic [32:0] sat_fre, sat_fim;
   logic [32:0] sat_p [NP];

   always_comb begin
      sat_fre = lle_pkg::sat32({1'b0, qsb_ff[QN-1].fre_mag}, qsb_ff[QN-1].fre_neg);
      sat_fim = lle_pkg::sat32({1'b0, qsb_ff[QN-1].fim_mag}, qsb_ff[QN-1].fim_neg);
      for (int k = 0; k < NP; k++) begin
         sat_p[k] = lle_pkg::sat32(pbig[k] ? 34'h3_FFFF_FFFF : {1'b0, pq[k]},
                                   qsb_ff[QN-1].p_neg[k]);
      end

      res = '0;
      if (lorentz_width_ff == 31'd0) begin
         // zero width: all numeric fields zero, flag set
         res.overflow = 1'b1;
      end else begin
         res.fit_re   = sat_fre[31:0];
         res.fit_im   = sat_fim[31:0];
         res.overflow = sat_fre[32] | sat_fim[32];
         if (gradients_on_ff) begin
            res.dpos_re    = sat_p[lle_pkg::P_POS_RE][31:0];
            res.dpos_im    = sat_p[lle_pkg::P_POS_IM][31:0];
            res.dwidth_re  = sat_p[lle_pkg::P_WIDTH_RE][31:0];
            res.dwidth_im  = sat_p[lle_pkg::P_WIDTH_IM][31:0];
            res.dheight_re = qsb_ff[QN-1].dh_re;
            res.dheight_im = qsb_ff[QN-1].dh_im;
            res.overflow   = sat_fre[32] | sat_fim[32] | sat_p[0][32] | sat_p[1][32]
                             | sat_p[2][32] | sat_p[3][32];
         end
      end
   end

   assign push = qsb_ff[QN-1].valid && advance;

   lle_out_buf u_out (
      .clock(clock), .reset(reset), .push(push), .push_data(res),
      .room(advance), .rsp_chan(rsp_chan)
   );

   `LLE_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_chan.valid, "rsp valid after reset")
   `LLE_ASSERT_RST(a_push_shows, clock, reset, push |=> rsp_chan.valid, "pushed result not shown")
   `LLE_ASSERT_RST(a_stall_holds, clock, reset, !advance |=> $stable(s1_valid_ff), "pipe moved in stall")

endmodule
